// File: rtl/core/u64_to_decimal_ascii_assert.svh
// Assertion macros shared by the decimal converter RTL.
`ifndef U64_TO_DECIMAL_ASCII_ASSERT_SVH
`define U64_TO_DECIMAL_ASCII_ASSERT_SVH

// cond true at an edge -> expr true at the same edge
`define U64DA_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("u64_to_decimal_ascii: assertion failed");

// cond true at an edge -> expr true at the next edge
`define U64DA_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("u64_to_decimal_ascii: assertion failed");

`endif

// File: rtl/core/u64da_pkg.sv
// Shared constants and helpers for the 64-bit binary to decimal ASCII converter.
package u64da_pkg;

    localparam int VALUE_W            = 64;
    localparam int DIGIT_W            = 4;
    localparam int ASCII_W            = 6;
    localparam int DEFAULT_MAX_DIGITS = 20;
    localparam int STEP_BITS          = 8;
    localparam int DD_STAGES          = VALUE_W / STEP_BITS;

    localparam logic [DIGIT_W-1:0] DD_THRESH = 4'd5;
    localparam logic [DIGIT_W-1:0] DD_ADJUST = 4'd3;
    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [ASCII_W-1:0] ASCII_NINE = 6'd57;

    function automatic logic [ASCII_W-1:0] to_ascii(input logic [DIGIT_W-1:0] digit);
        logic [ASCII_W-1:0] code;
        code = ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, digit};
        return code;
    endfunction

endpackage

// File: rtl/core/u64da_dd_stage.sv
// One double-dabble pipeline stage: shifts STEP_BITS value bits into the BCD digits.
module u64da_dd_stage #(
    parameter int MAX_DIGITS = u64da_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     up_valid,
    output logic                                     up_ready,
    input  logic [MAX_DIGITS*u64da_pkg::DIGIT_W-1:0] up_bcd,
    input  logic [u64da_pkg::VALUE_W-1:0]            up_bin,
    output logic                                     dn_valid,
    input  logic                                     dn_ready,
    output logic [MAX_DIGITS*u64da_pkg::DIGIT_W-1:0] dn_bcd,
    output logic [u64da_pkg::VALUE_W-1:0]            dn_bin
);

    localparam int BCD_W = MAX_DIGITS * u64da_pkg::DIGIT_W;
    localparam int DW    = u64da_pkg::DIGIT_W;
    localparam int VW    = u64da_pkg::VALUE_W;

    logic             valid_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [VW-1:0]    bin_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [VW-1:0]    bin_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_bcd   = bcd_reg;
    assign dn_bin   = bin_reg;

    // add-3 then shift, one value bit per step; carry out of the top digit drops
    always_comb
    begin
        bcd_next = up_bcd;
        bin_next = up_bin;
        for (int s = 0; s < u64da_pkg::STEP_BITS; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (bcd_next[d*DW +: DW] >= u64da_pkg::DD_THRESH)
                begin
                    bcd_next[d*DW +: DW] = bcd_next[d*DW +: DW] + u64da_pkg::DD_ADJUST;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[VW-1]};
            bin_next = {bin_next[VW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

endmodule

// File: rtl/core/u64da_serializer.sv
// Output serializer: drops leading zeros and emits one ASCII digit per item.
module u64da_serializer #(
    parameter int MAX_DIGITS = u64da_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     load_valid,
    output logic                                     load_ready,
    input  logic [MAX_DIGITS*u64da_pkg::DIGIT_W-1:0] load_bcd,
    output logic                                     char_valid,
    input  logic                                     char_stall,
    output logic [u64da_pkg::ASCII_W-1:0]            ascii_char,
    output logic                                     is_last
);

    localparam int DW = u64da_pkg::DIGIT_W;
    localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic          busy_reg;
    logic [PW-1:0] pos_reg;
    logic [DW-1:0] digits_reg [MAX_DIGITS];
    logic [PW-1:0] pos_next;

    // index of the most significant nonzero digit, zero for a zero value
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (load_bcd[i*DW +: DW] != '0)
            begin
                pos_next = PW'(i);
            end
        end
    end

    assign load_ready = !busy_reg || (!char_stall && (pos_reg == '0));
    assign char_valid = busy_reg;
    assign ascii_char = u64da_pkg::to_ascii(digits_reg[pos_reg]);
    assign is_last    = (pos_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (load_ready)
        begin
            busy_reg <= load_valid;
            if (load_valid)
            begin
                pos_reg <= pos_next;
            end
        end
        else if (!char_stall)
        begin
            pos_reg <= pos_reg - PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                digits_reg[i] <= load_bcd[i*DW +: DW];
            end
        end
    end

endmodule

// File: rtl/core/u64_to_decimal_ascii.sv
// Top level: 64-bit unsigned value to decimal ASCII digits, most significant first.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+--------------------------
//  value    | value_valid | value_stall | value[63:0]
//  char     | char_valid  | char_stall  | ascii_char[5:0], is_last
//
// A value passes through DD_STAGES (8) double-dabble stages into the serializer, which
// sends one character per cycle while char_stall is low and loads the next value as the
// last character leaves; the value rate is set by the single character port and each
// value's digit count (1 to MAX_DIGITS). Up to 8 further values wait in the pipeline.
// Reset clears the valid bits and the digit pointer. A char stall backs up through
// the stages and raises value_stall once the first stage holds an item it cannot pass on.
module u64_to_decimal_ascii #(
    parameter int MAX_DIGITS = u64da_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            value_valid,
    output logic                            value_stall,
    input  logic [u64da_pkg::VALUE_W-1:0]   value,
    output logic                            char_valid,
    input  logic                            char_stall,
    output logic [u64da_pkg::ASCII_W-1:0]   ascii_char,
    output logic                            is_last
);

    `include "u64_to_decimal_ascii_assert.svh"

    localparam int BCD_W  = MAX_DIGITS * u64da_pkg::DIGIT_W;
    localparam int STAGES = u64da_pkg::DD_STAGES;

    logic                          valid_w [STAGES+1];
    logic                          ready_w [STAGES+1];
    logic [BCD_W-1:0]              bcd_w   [STAGES+1];
    logic [u64da_pkg::VALUE_W-1:0] bin_w   [STAGES+1];
    logic                          char_in_range;

    assign valid_w[0]  = value_valid;
    assign bcd_w[0]    = '0;
    assign bin_w[0]    = value;
    assign value_stall = !ready_w[0];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_dd
        u64da_dd_stage #(
            .MAX_DIGITS(MAX_DIGITS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_w[g]),
            .up_ready (ready_w[g]),
            .up_bcd   (bcd_w[g]),
            .up_bin   (bin_w[g]),
            .dn_valid (valid_w[g+1]),
            .dn_ready (ready_w[g+1]),
            .dn_bcd   (bcd_w[g+1]),
            .dn_bin   (bin_w[g+1])
        );
    end

    u64da_serializer #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (valid_w[STAGES]),
        .load_ready (ready_w[STAGES]),
        .load_bcd   (bcd_w[STAGES]),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .is_last    (is_last)
    );

    assign char_in_range = (ascii_char >= u64da_pkg::ASCII_ZERO) &&
                           (ascii_char <= u64da_pkg::ASCII_NINE);

    `U64DA_ASSERT_IMPL(a_char_is_digit, char_valid, char_in_range)
    `U64DA_ASSERT_NEXT(a_run_continues, char_valid && !char_stall && !is_last, char_valid)
    `U64DA_ASSERT_IMPL(a_stall_when_full, value_stall, valid_w[1])

endmodule
